/* sv/gnsd_pkg.sv */
// ----------------------------------------------------------------------------
// gnsd_pkg
// Shared widths, payload types, register indexes and the microcode program
// of the greedy nearest-server dispatcher.
// ----------------------------------------------------------------------------
package gnsd_pkg;

  // coordinate and fixed-point widths
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 8;
  localparam int REG_W      = 10;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int D2_W       = 2 * COORD_BITS + 1;
  localparam int ROOT_W     = COORD_BITS + FRAC_BITS + 1;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SH_W       = 2 * ROOT_W;
  localparam int K_W        = $clog2(ROOT_W);
  localparam int STEP_W     = 19;
  localparam int TOTAL_W    = 32;
  localparam int SRV_W      = 2;
  localparam int NUM_SRV    = 3;

  // configuration registers
  localparam int NUM_CFG   = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_Y   = 3'd5;

  localparam logic [REG_W-1:0] RED_X_RESET  = 10'd600;
  localparam logic [REG_W-1:0] BLUE_X_RESET = 10'd300;
  localparam logic [REG_W-1:0] BLUE_Y_RESET = 10'd400;

  // server identities
  localparam logic [SRV_W-1:0] SRV_YELLOW = 2'd0;
  localparam logic [SRV_W-1:0] SRV_RED    = 2'd1;
  localparam logic [SRV_W-1:0] SRV_BLUE   = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // payload types
  typedef struct packed {
    logic [COORD_BITS-1:0] request_x;
    logic [COORD_BITS-1:0] request_y;
    logic                  first_request;
  } in_t;

  typedef struct packed {
    logic [SRV_W-1:0]   server_moved;
    logic [STEP_W-1:0]  step_distance;
    logic [TOTAL_W-1:0] total_distance;
    logic               no_unique_nearest;
  } out_t;

  // micro-operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SQX    = 3'd2;
  localparam logic [OP_W-1:0] OP_SQY    = 3'd3;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd4;
  localparam logic [OP_W-1:0] OP_ROOT   = 3'd5;
  localparam logic [OP_W-1:0] OP_DONE   = 3'd6;

  // hold conditions
  localparam int WT_W = 2;
  localparam logic [WT_W-1:0] W_NONE = 2'd0;
  localparam logic [WT_W-1:0] W_IN   = 2'd1;
  localparam logic [WT_W-1:0] W_OUT  = 2'd2;

  // sequencing after a step
  localparam int JMP_W = 2;
  localparam logic [JMP_W-1:0] J_NEXT   = 2'd0;
  localparam logic [JMP_W-1:0] J_ALWAYS = 2'd1;
  localparam logic [JMP_W-1:0] J_MORE   = 2'd2;

  // program addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] PC_SQX_Y  = 4'd1;
  localparam logic [PC_W-1:0] PC_SQY_Y  = 4'd2;
  localparam logic [PC_W-1:0] PC_SQX_R  = 4'd3;
  localparam logic [PC_W-1:0] PC_SQY_R  = 4'd4;
  localparam logic [PC_W-1:0] PC_SQX_B  = 4'd5;
  localparam logic [PC_W-1:0] PC_SQY_B  = 4'd6;
  localparam logic [PC_W-1:0] PC_SELECT = 4'd7;
  localparam logic [PC_W-1:0] PC_ROOT   = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE   = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SRV_W-1:0] srv;
    logic [WT_W-1:0]  wt;
    logic [JMP_W-1:0] jmp;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic root_more;
    logic out_busy;
  } stat_t;

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, srv: SRV_YELLOW, wt: W_NONE, jmp: J_ALWAYS, target: PC_LOAD};
    unique case (pc)
      PC_LOAD:   w = '{OP_LOAD,   SRV_YELLOW, W_IN,   J_NEXT,   PC_LOAD};
      PC_SQX_Y:  w = '{OP_SQX,    SRV_YELLOW, W_NONE, J_NEXT,   PC_LOAD};
      PC_SQY_Y:  w = '{OP_SQY,    SRV_YELLOW, W_NONE, J_NEXT,   PC_LOAD};
      PC_SQX_R:  w = '{OP_SQX,    SRV_RED,    W_NONE, J_NEXT,   PC_LOAD};
      PC_SQY_R:  w = '{OP_SQY,    SRV_RED,    W_NONE, J_NEXT,   PC_LOAD};
      PC_SQX_B:  w = '{OP_SQX,    SRV_BLUE,   W_NONE, J_NEXT,   PC_LOAD};
      PC_SQY_B:  w = '{OP_SQY,    SRV_BLUE,   W_NONE, J_NEXT,   PC_LOAD};
      PC_SELECT: w = '{OP_SELECT, SRV_YELLOW, W_NONE, J_NEXT,   PC_LOAD};
      PC_ROOT:   w = '{OP_ROOT,   SRV_YELLOW, W_NONE, J_MORE,   PC_ROOT};
      PC_DONE:   w = '{OP_DONE,   SRV_YELLOW, W_OUT,  J_ALWAYS, PC_LOAD};
      default:   w = '{OP_NOP,    SRV_YELLOW, W_NONE, J_ALWAYS, PC_LOAD};
    endcase
    return w;
  endfunction

  // register value to coordinate width
  function automatic logic [COORD_BITS-1:0] to_coord(input logic [REG_W-1:0] v);
    logic [REG_W+COORD_BITS-1:0] t;
    t = {{COORD_BITS{1'b0}}, v};
    return t[COORD_BITS-1:0];
  endfunction

  // root to step field, saturating
  function automatic logic [STEP_W-1:0] sat_step(input logic [ROOT_W-1:0] r);
    logic [ROOT_W+STEP_W-1:0] w;
    logic [ROOT_W+STEP_W-1:0] lim;
    w   = {{STEP_W{1'b0}}, r};
    lim = {{ROOT_W{1'b0}}, STEP_MAX};
    return (w > lim) ? STEP_MAX : w[STEP_W-1:0];
  endfunction

endpackage

/* sv/gnsd_seq.sv */
// ----------------------------------------------------------------------------
// gnsd_seq
// Microcode sequencer: step counter, control store read, hold conditions
// and conditional jumps.
// ----------------------------------------------------------------------------
module gnsd_seq import gnsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  in_stall
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ctrl_t           word;
  logic            hold;

  // control word of the current step
  assign word     = ucode(pc_r);
  assign in_stall = (word.op != OP_LOAD);

  // step waits on the input or on the output register
  always_comb begin
    hold = 1'b0;
    unique case (word.wt)
      W_IN:    hold = !in_valid;
      W_OUT:   hold = stat.out_busy;
      default: hold = 1'b0;
    endcase
  end

  // a held step issues no operation
  always_comb begin
    ctrl = word;
    if (hold) begin
      ctrl.op = OP_NOP;
    end
  end

  // next step
  always_comb begin
    pc_nxt = pc_r + 1'b1;
    if (hold) begin
      pc_nxt = pc_r;
    end else begin
      unique case (word.jmp)
        J_ALWAYS: pc_nxt = word.target;
        J_MORE:   pc_nxt = stat.root_more ? word.target : pc_r + 1'b1;
        default:  pc_nxt = pc_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* sv/gnsd_datapath.sv */
// ----------------------------------------------------------------------------
// gnsd_datapath
// Start registers, server positions, shared squarer, nearest selection,
// digit-by-digit square root, running total and the output register.
// ----------------------------------------------------------------------------
module gnsd_datapath import gnsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctrl,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_t                 out_data,
  output stat_t                stat
);

  logic [REG_W-1:0]      cfg_r   [NUM_CFG];
  logic [COORD_BITS-1:0] pos_x_r [NUM_SRV];
  logic [COORD_BITS-1:0] pos_y_r [NUM_SRV];
  logic [D2_W-1:0]       dist_r  [NUM_SRV];
  logic [COORD_BITS-1:0] req_x_r;
  logic [COORD_BITS-1:0] req_y_r;
  logic [SQ_W-1:0]       acc_r;
  logic [SRV_W-1:0]      sel_r;
  logic                  tie_r;
  logic [SH_W-1:0]       sh_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_W-1:0]     root_nxt;
  logic [REM_W-1:0]      rem_r;
  logic [REM_W-1:0]      rem_nxt;
  logic [K_W-1:0]        k_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [TOTAL_W-1:0]    total_nxt;
  logic                  out_valid_r;
  out_t                  out_r;

  logic [COORD_BITS-1:0] p_coord;
  logic [COORD_BITS-1:0] r_coord;
  logic [COORD_BITS-1:0] diff;
  logic [SQ_W-1:0]       sq;
  logic [SRV_W-1:0]      sel_nxt;
  logic                  tie_nxt;
  logic [D2_W-1:0]       d2_sel;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic [STEP_W-1:0]     step;
  logic [TOTAL_W:0]      sum;

  // squarer operands: one server coordinate against the request
  always_comb begin
    p_coord = pos_x_r[0];
    r_coord = (ctrl.op == OP_SQY) ? req_y_r : req_x_r;
    unique case (ctrl.srv)
      SRV_RED:  p_coord = (ctrl.op == OP_SQY) ? pos_y_r[1] : pos_x_r[1];
      SRV_BLUE: p_coord = (ctrl.op == OP_SQY) ? pos_y_r[2] : pos_x_r[2];
      default:  p_coord = (ctrl.op == OP_SQY) ? pos_y_r[0] : pos_x_r[0];
    endcase
  end

  assign diff = (p_coord > r_coord) ? p_coord - r_coord : r_coord - p_coord;
  assign sq   = SQ_W'(diff) * SQ_W'(diff);

  // strictly nearest server, red when there is none
  always_comb begin
    tie_nxt = 1'b0;
    if (dist_r[2] < dist_r[1] && dist_r[2] < dist_r[0]) begin
      sel_nxt = SRV_BLUE;
    end else if (dist_r[1] < dist_r[2] && dist_r[1] < dist_r[0]) begin
      sel_nxt = SRV_RED;
    end else if (dist_r[0] < dist_r[2] && dist_r[0] < dist_r[1]) begin
      sel_nxt = SRV_YELLOW;
    end else begin
      sel_nxt = SRV_RED;
      tie_nxt = 1'b1;
    end
  end

  always_comb begin
    unique case (sel_nxt)
      SRV_YELLOW: d2_sel = dist_r[0];
      SRV_BLUE:   d2_sel = dist_r[2];
      default:    d2_sel = dist_r[1];
    endcase
  end

  // one root digit per step
  assign rem_sh = {rem_r[REM_W-3:0], sh_r[SH_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  // saturating running total
  assign step      = sat_step(root_r);
  assign sum       = {1'b0, total_r} + {{(TOTAL_W+1-STEP_W){1'b0}}, step};
  assign total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // start registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= '0;
      end
      cfg_r[REG_RED_X]  <= RED_X_RESET;
      cfg_r[REG_BLUE_X] <= BLUE_X_RESET;
      cfg_r[REG_BLUE_Y] <= BLUE_Y_RESET;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          cfg_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // server positions and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r[0] <= '0;
      pos_y_r[0] <= '0;
      pos_x_r[1] <= to_coord(RED_X_RESET);
      pos_y_r[1] <= '0;
      pos_x_r[2] <= to_coord(BLUE_X_RESET);
      pos_y_r[2] <= to_coord(BLUE_Y_RESET);
      total_r    <= '0;
    end else if (ctrl.op == OP_LOAD && in_data.first_request) begin
      for (int s = 0; s < NUM_SRV; s++) begin
        pos_x_r[s] <= to_coord(cfg_r[2*s]);
        pos_y_r[s] <= to_coord(cfg_r[2*s+1]);
      end
      total_r <= '0;
    end else if (ctrl.op == OP_DONE) begin
      for (int s = 0; s < NUM_SRV; s++) begin
        if (sel_r == SRV_W'(s)) begin
          pos_x_r[s] <= req_x_r;
          pos_y_r[s] <= req_y_r;
        end
      end
      total_r <= total_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        req_x_r <= in_data.request_x;
        req_y_r <= in_data.request_y;
      end
      OP_SQX: begin
        acc_r <= sq;
      end
      OP_SQY: begin
        for (int s = 0; s < NUM_SRV; s++) begin
          if (ctrl.srv == SRV_W'(s)) begin
            dist_r[s] <= {1'b0, acc_r} + {1'b0, sq};
          end
        end
      end
      OP_SELECT: begin
        sel_r  <= sel_nxt;
        tie_r  <= tie_nxt;
        sh_r   <= {{(SH_W-D2_W){1'b0}}, d2_sel} << (2 * FRAC_BITS);
        root_r <= '0;
        rem_r  <= '0;
        k_r    <= K_W'(ROOT_W - 1);
      end
      OP_ROOT: begin
        sh_r   <= sh_r << 2;
        root_r <= root_nxt;
        rem_r  <= rem_nxt;
        k_r    <= k_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_DONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_DONE) begin
      out_r.server_moved      <= sel_r;
      out_r.step_distance     <= step;
      out_r.total_distance    <= total_nxt;
      out_r.no_unique_nearest <= tie_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.root_more = (k_r != '0);
  assign stat.out_busy  = out_valid_r && out_stall;

endmodule

/* sv/greedy_nearest_server_dispatch.sv */
// ----------------------------------------------------------------------------
// greedy_nearest_server_dispatch
// Sends each request point to the strictly nearest of three servers and
// reports the move, its length and a saturating running total.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_stall/in_data carry request transfers; out_valid/out_stall/
//   out_data carry result transfers, exactly one result per request.
//   cfg_we/cfg_index/cfg_wdata write the six start coordinates; they take
//   effect when a request with first_request set arrives, which also clears
//   the running total. Write them only while the block is idle.
//   A request is taken on the load step, then three squared distances are
//   built (two squarer passes each), the nearest server is chosen and a
//   19-step digit-by-digit square root runs. The done step then registers
//   the result, and the load step for the next request follows in the
//   next cycle; no new request is taken before the last one is finished.
//   If the receiver stalls, the result waits in the output register and the
//   next request is still taken; a second result then waits for the first.
//   Reset restores the start registers to their reset values, places the
//   servers there and clears the total and the output valid flag.
// ----------------------------------------------------------------------------
module greedy_nearest_server_dispatch import gnsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  ctrl_t ctrl;
  stat_t stat;

  // microcode sequencer
  gnsd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // datapath
  gnsd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule
